// ----- hdl/tlmc_pkg.sv -----
// Types, codes and helpers for the traffic light mode controller.
// No dependencies; imported by tlmc_core and the top level.
`timescale 1ns / 1ps
package tlmc_pkg;

  localparam logic [7:0] MAX_TIME = 8'd99;
  localparam logic [7:0] MIN_TIME = 8'd1;

  localparam logic [3:0] ST_INIT     = 4'd0;
  localparam logic [3:0] ST_AUTO_RG  = 4'd1;
  localparam logic [3:0] ST_AUTO_RY  = 4'd2;
  localparam logic [3:0] ST_AUTO_GR  = 4'd3;
  localparam logic [3:0] ST_AUTO_YR  = 4'd4;
  localparam logic [3:0] ST_MAN_RG   = 4'd5;
  localparam logic [3:0] ST_MAN_RY   = 4'd6;
  localparam logic [3:0] ST_MAN_GR   = 4'd7;
  localparam logic [3:0] ST_MAN_YR   = 4'd8;
  localparam logic [3:0] ST_RED_EDIT = 4'd9;
  localparam logic [3:0] ST_BLINK    = 4'd15;

  localparam logic [1:0] REG_TPS  = 2'd0;
  localparam logic [1:0] REG_FAST = 2'd1;
  localparam logic [1:0] REG_SLOW = 2'd2;
  localparam logic [1:0] REG_DIG  = 2'd3;

  // lamp bit patterns, way 0 in [2:0], way 1 in [5:3]
  localparam logic [5:0] LAMPS_RG = 6'b100_001;
  localparam logic [5:0] LAMPS_RY = 6'b010_001;
  localparam logic [5:0] LAMPS_GR = 6'b001_100;
  localparam logic [5:0] LAMPS_YR = 6'b001_010;
  localparam logic [5:0] LAMPS_YY = 6'b010_010;

  typedef struct packed {
    logic tick;
    logic mode_button_press;
    logic adjust_button_press;
    logic adjust_button_long;
    logic select_button_press;
  } tlmc_in_t;

  typedef struct packed {
    logic [2:0] way0_lamps;
    logic [2:0] way1_lamps;
    logic [7:0] left_display;
    logic [7:0] right_display;
    logic [3:0] digit_enables;
    logic [3:0] state_code;
  } tlmc_out_t;

  typedef struct packed {
    logic [23:0] cnt;
    logic        flag;
  } tmr24_t;

  typedef struct packed {
    logic [15:0] cnt;
    logic        flag;
  } tmr16_t;

  typedef struct packed {
    logic [15:0] tps;
    logic [15:0] fast;
    logic [15:0] slow;
    logic [15:0] dig;
  } tlmc_cfg_t;

  typedef struct packed {
    logic [3:0] state;
    logic [7:0] red;
    logic [7:0] yellow;
    logic [7:0] green;
    logic [7:0] edit;
    tmr24_t     phase;
    tmr16_t     second;
    tmr16_t     blink;
    tmr16_t     dblink;
    logic [7:0] cd0;
    logic [7:0] cd1;
    logic [5:0] lamps;
    logic [2:0] pend;
    logic [3:0] mask;
  } tlmc_state_t;

  function automatic tmr16_t load16(input logic [15:0] d);
    tmr16_t t;
    t.cnt  = (d == 16'd0) ? 16'd1 : d;
    t.flag = 1'b0;
    return t;
  endfunction

  function automatic tmr16_t tick16(input tmr16_t t);
    tmr16_t r;
    r = t;
    if (t.cnt != 16'd0) begin
      r.cnt = t.cnt - 16'd1;
      if (r.cnt == 16'd0) r.flag = 1'b1;
    end
    return r;
  endfunction

  function automatic tmr24_t tick24(input tmr24_t t);
    tmr24_t r;
    r = t;
    if (t.cnt != 24'd0) begin
      r.cnt = t.cnt - 24'd1;
      if (r.cnt == 24'd0) r.flag = 1'b1;
    end
    return r;
  endfunction

endpackage

// ----- hdl/tlmc_core.sv -----
// Next-state logic for one item: timers, press latching, mode actions and
// state entry. Depends on tlmc_pkg.
`timescale 1ns / 1ps
module tlmc_core import tlmc_pkg::*; (
  input  tlmc_state_t st,
  input  tlmc_cfg_t   cfg,
  input  tlmc_in_t    item,
  output tlmc_state_t nx
);

  logic       go_auto, go_man, go_edit, go_blink, full, ch, e_ch;
  logic [3:0] auto_s, man_s;
  logic [1:0] w, e_w;
  logic [8:0] e;
  logic [7:0] mul_a, which, r_sum;
  logic [8:0] g_sum;
  logic [23:0] prod;
  logic [2:0] wbit;

  always_comb begin
    nx = st;
    go_auto = 1'b0; go_man = 1'b0; go_edit = 1'b0; go_blink = 1'b0;
    auto_s = ST_AUTO_RG; man_s = ST_MAN_RG; e_w = 2'd0; e_ch = 1'b0;
    w = 2'd0; ch = 1'b0; e = 9'd0; which = 8'd0; g_sum = 9'd0; r_sum = 8'd0;
    wbit = 3'd0; full = 1'b0; mul_a = 8'd0; prod = 24'd0;

    if (item.tick) begin
      nx.phase  = tick24(st.phase);
      nx.second = tick16(st.second);
      nx.blink  = tick16(st.blink);
      nx.dblink = tick16(st.dblink);
    end
    nx.pend = st.pend | {item.select_button_press, item.adjust_button_press,
                         item.mode_button_press};

    case (st.state)
      ST_INIT: begin
        go_auto = 1'b1;
        auto_s  = ST_AUTO_RG;
      end
      ST_AUTO_RG, ST_AUTO_RY, ST_AUTO_GR, ST_AUTO_YR: begin
        case (st.state)
          ST_AUTO_RG: nx.lamps = LAMPS_RG;
          ST_AUTO_RY: nx.lamps = LAMPS_RY;
          ST_AUTO_GR: nx.lamps = LAMPS_GR;
          default:    nx.lamps = LAMPS_YR;
        endcase
        if (nx.second.flag) begin
          nx.cd0    = nx.cd0 - 8'd1;
          nx.cd1    = nx.cd1 - 8'd1;
          nx.second = load16(cfg.tps);
        end
        if (nx.phase.flag) begin
          go_auto = 1'b1;
          auto_s  = (st.state == ST_AUTO_YR) ? ST_AUTO_RG : st.state + 4'd1;
        end else if (nx.pend[0]) begin
          nx.pend[0] = 1'b0;
          go_edit = 1'b1;
        end else if (nx.pend[1]) begin
          nx.pend[1] = 1'b0;
          go_blink = 1'b1;
        end else if ((st.state == ST_AUTO_RG || st.state == ST_AUTO_GR) && nx.pend[2]) begin
          nx.pend[2] = 1'b0;
          go_man = 1'b1;
          man_s  = st.state + 4'd4;
        end
      end
      ST_MAN_RG, ST_MAN_GR: begin
        nx.mask  = 4'h0;
        nx.lamps = (st.state == ST_MAN_RG) ? LAMPS_RG : LAMPS_GR;
        if (nx.pend[1]) begin
          nx.pend[1] = 1'b0;
          go_man = 1'b1;
          man_s  = st.state + 4'd1;
        end else if (nx.pend[2]) begin
          nx.pend[2] = 1'b0;
          go_auto = 1'b1;
          auto_s  = st.state - 4'd4;
        end
      end
      ST_MAN_RY, ST_MAN_YR: begin
        nx.mask  = 4'h0;
        nx.lamps = (st.state == ST_MAN_RY) ? LAMPS_RY : LAMPS_YR;
        if (nx.phase.flag) begin
          go_man = 1'b1;
          man_s  = (st.state == ST_MAN_RY) ? ST_MAN_GR : ST_MAN_RG;
        end
      end
      ST_BLINK: begin
        if (nx.blink.flag) begin
          nx.lamps = nx.lamps ^ LAMPS_YY;
          nx.blink = load16(cfg.slow);
        end
        if (nx.pend[1]) begin
          nx.pend[1] = 1'b0;
          go_auto = 1'b1;
          auto_s  = ST_AUTO_RG;
        end
      end
      default: begin
        w  = 2'((st.state - ST_RED_EDIT) >> 1);
        ch = ~st.state[0];
        e  = {1'b0, st.edit} + {8'd0, nx.pend[1]} + (item.adjust_button_long ? 9'd5 : 9'd0);
        nx.pend[1] = 1'b0;
        if (e > {1'b0, MAX_TIME}) e = {1'b0, MIN_TIME};
        nx.edit = e[7:0];
        if (ch && nx.pend[2]) begin
          nx.pend[2] = 1'b0;
          case (w)
            2'd0: if (nx.edit > nx.yellow) begin
              nx.red   = nx.edit;
              nx.green = nx.edit - nx.yellow;
            end
            2'd1: if (nx.red > nx.edit) begin
              nx.yellow = nx.edit;
              nx.green  = nx.red - nx.edit;
            end
            default: begin
              g_sum    = {1'b0, nx.edit} + {1'b0, nx.yellow};
              nx.green = nx.edit;
              nx.red   = g_sum[8] ? 8'hFF : g_sum[7:0];
            end
          endcase
        end
        nx.cd0 = nx.edit;
        wbit = 3'd1 << w;
        if (nx.blink.flag) begin
          nx.lamps = nx.lamps ^ {wbit, wbit};
          nx.blink = load16(cfg.fast);
        end
        if (ch && nx.dblink.flag) begin
          nx.mask   = nx.mask[0] ? (nx.mask & 4'hC) : (nx.mask | 4'h3);
          nx.dblink = load16(cfg.dig);
        end
        which = (w == 2'd0) ? nx.red : ((w == 2'd1) ? nx.yellow : nx.green);
        if (nx.pend[0]) begin
          nx.pend[0] = 1'b0;
          if (w == 2'd2) begin
            go_auto = 1'b1;
            auto_s  = ST_AUTO_RG;
          end else begin
            go_edit = 1'b1;
            e_w     = w + 2'd1;
          end
        end else if (!ch && nx.edit != which) begin
          go_edit = 1'b1; e_w = w; e_ch = 1'b1;
        end else if (ch && nx.edit == which) begin
          go_edit = 1'b1; e_w = w;
        end
      end
    endcase

    full  = (auto_s == ST_AUTO_RG || auto_s == ST_AUTO_GR);
    mul_a = (go_auto && full) ? nx.green : nx.yellow;
    prod  = mul_a * cfg.tps;

    if (go_auto) begin
      nx.phase.cnt  = (prod == 24'd0) ? 24'd1 : prod;
      nx.phase.flag = 1'b0;
      nx.pend       = full ? 3'b000 : (nx.pend & 3'b100);
      nx.mask       = 4'hF;
      nx.second     = load16(cfg.tps);
      case (auto_s)
        ST_AUTO_RG: begin nx.cd0 = nx.red;    nx.cd1 = nx.green;  end
        ST_AUTO_GR: begin nx.cd0 = nx.green;  nx.cd1 = nx.red;    end
        default:    begin nx.cd0 = nx.yellow; nx.cd1 = nx.yellow; end
      endcase
      nx.state = auto_s;
    end
    if (go_man) begin
      if (man_s == ST_MAN_RG || man_s == ST_MAN_GR) begin
        nx.pend = nx.pend & 3'b001;
      end else begin
        nx.phase.cnt  = (prod == 24'd0) ? 24'd1 : prod;
        nx.phase.flag = 1'b0;
      end
      nx.state = man_s;
    end
    if (go_edit) begin
      wbit = 3'd1 << e_w;
      if (e_ch) begin
        nx.pend = nx.pend & 3'b010;
      end else begin
        nx.pend[0] = 1'b0;
        nx.edit = (e_w == 2'd0) ? nx.red : ((e_w == 2'd1) ? nx.yellow : nx.green);
      end
      nx.lamps = {wbit, wbit};
      nx.blink = load16(cfg.fast);
      nx.mask  = 4'hF;
      nx.cd0   = nx.edit;
      r_sum    = {4'd0, ST_RED_EDIT} + {5'd0, e_w, 1'b0} + {7'd0, e_ch};
      nx.cd1   = r_sum;
      if (e_ch) nx.dblink = load16(cfg.dig);
      nx.state = r_sum[3:0];
    end
    if (go_blink) begin
      nx.pend[1] = 1'b0;
      nx.lamps   = LAMPS_YY;
      nx.mask    = 4'h0;
      nx.blink   = load16(cfg.slow);
      nx.state   = ST_BLINK;
    end
  end

endmodule

// ----- hdl/traffic_light_mode_controller_top.sv -----
// Top level of the traffic light mode controller: configuration registers,
// controller state and the result register. Depends on tlmc_pkg, tlmc_core.
//
// Usage: each input item on in_data is one pass of the control loop (an
// optional timer tick and button events). It is accepted when in_valid and
// in_ready are both high. Every item yields exactly one result item on
// out_data with lamps, display values, digit enables and the state code.
// The result of an item is valid in the cycle after it is accepted.
// Throughput is one item per cycle while the receiver does not stall, set
// by the combinational next-state logic and the one result register.
// If the receiver stalls, the result register holds its item and in_ready
// drops only while that item still waits; an item arriving in the cycle the
// result is taken is accepted at once.
// The configuration port (cfg_we, cfg_index, cfg_data) writes one register
// per cycle. Use it only while the block is idle; it does not enforce this.
// Synchronous reset puts the controller in its initial state with the
// default times, clears timers and pending presses, restores the default
// register values and empties the result register.
`timescale 1ns / 1ps
module traffic_light_mode_controller_top import tlmc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  tlmc_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output tlmc_out_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  tlmc_state_t st, st_next;
  tlmc_cfg_t   cfg;
  logic        accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  tlmc_core u_core (
    .st   (st),
    .cfg  (cfg),
    .item (in_data),
    .nx   (st_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tps  <= 16'd1000;
      cfg.fast <= 16'd250;
      cfg.slow <= 16'd500;
      cfg.dig  <= 16'd250;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TPS:  cfg.tps  <= cfg_data;
        REG_FAST: cfg.fast <= cfg_data;
        REG_SLOW: cfg.slow <= cfg_data;
        REG_DIG:  cfg.dig  <= cfg_data;
        default:  cfg.tps  <= cfg.tps;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.state  <= ST_INIT;
      st.red    <= 8'd5;
      st.yellow <= 8'd2;
      st.green  <= 8'd3;
      st.edit   <= 8'd0;
      st.phase  <= '0;
      st.second <= '0;
      st.blink  <= '0;
      st.dblink <= '0;
      st.cd0    <= 8'd0;
      st.cd1    <= 8'd0;
      st.lamps  <= 6'd0;
      st.pend   <= 3'd0;
      st.mask   <= 4'd0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.way0_lamps    <= st_next.lamps[2:0];
      out_data.way1_lamps    <= st_next.lamps[5:3];
      out_data.left_display  <= st_next.cd0;
      out_data.right_display <= st_next.cd1;
      out_data.digit_enables <= st_next.mask;
      out_data.state_code    <= st_next.state;
    end
  end

endmodule

// ----- tb/traffic_light_mode_controller_top_tb.sv -----
// Self-checking testbench for the traffic light mode controller top level.
// A built-in model predicts each result item; depends on tlmc_pkg and the RTL.
`timescale 1ns / 1ps
module traffic_light_mode_controller_top_tb import tlmc_pkg::*;;

  localparam int LIMIT = 400000;

  typedef struct {
    int unsigned cnt;
    bit flag;
  } cdown_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  tlmc_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tlmc_out_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_TPS;
  logic [15:0] cfg_data = '0;

  traffic_light_mode_controller_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // model of the controller
  int unsigned m_tps = 1000, m_fast = 250, m_slow = 500, m_dig = 250;
  logic [3:0] m_state = ST_INIT;
  int unsigned m_red = 5, m_yel = 2, m_grn = 3, m_edit = 0;
  cdown_t m_phase = '{0, 0}, m_sec = '{0, 0}, m_blink = '{0, 0}, m_dblink = '{0, 0};
  int unsigned m_cd0 = 0, m_cd1 = 0;
  int unsigned m_lamps = 0, m_pend = 0, m_mask = 0;

  tlmc_in_t pending_items[$];
  tlmc_out_t expected_lights[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int cycles = 0;
  bit [15:0] seen_states = '0;

  function automatic cdown_t arm(int unsigned d);
    cdown_t t;
    t.cnt = (d == 0) ? 1 : d;
    t.flag = 1'b0;
    return t;
  endfunction

  function automatic cdown_t count_down(cdown_t t);
    cdown_t r = t;
    if (t.cnt > 0) begin
      r.cnt = t.cnt - 1;
      if (r.cnt == 0) r.flag = 1'b1;
    end
    return r;
  endfunction

  function automatic bit grab(int b);
    bit p;
    p = m_pend[b];
    m_pend = m_pend & ~(1 << b) & 7;
    return p;
  endfunction

  function automatic void drop(int unsigned msk);
    m_pend = m_pend & ~msk & 7;
  endfunction

  function automatic int unsigned both_ways(int unsigned c);
    return c | (c << 3);
  endfunction

  function automatic int unsigned edited_time(int unsigned w);
    return w == 0 ? m_red : (w == 1 ? m_yel : m_grn);
  endfunction

  function automatic void go_auto(logic [3:0] s);
    bit full;
    full = (s == ST_AUTO_RG || s == ST_AUTO_GR);
    m_phase = arm((full ? m_grn : m_yel) * m_tps);
    drop(full ? 7 : 3);
    m_mask = 4'hF;
    m_sec = arm(m_tps);
    if (s == ST_AUTO_RG) begin
      m_cd0 = m_red; m_cd1 = m_grn;
    end else if (s == ST_AUTO_GR) begin
      m_cd0 = m_grn; m_cd1 = m_red;
    end else begin
      m_cd0 = m_yel; m_cd1 = m_yel;
    end
    m_state = s;
  endfunction

  function automatic void go_manual(logic [3:0] s);
    if (s == ST_MAN_RG || s == ST_MAN_GR) drop(6);
    else m_phase = arm(m_yel * m_tps);
    m_state = s;
  endfunction

  function automatic void go_edit(int unsigned w, bit chg);
    if (chg) drop(5);
    else begin
      drop(1);
      m_edit = edited_time(w);
    end
    m_lamps = both_ways(1 << w);
    m_blink = arm(m_fast);
    m_mask = 4'hF;
    m_cd0 = m_edit;
    m_cd1 = ST_RED_EDIT + 2 * w + chg;
    if (chg) m_dblink = arm(m_dig);
    m_state = 4'(ST_RED_EDIT + 2 * w + chg);
  endfunction

  function automatic void run_edit(int unsigned w, bit chg, bit lp);
    int unsigned e;
    int unsigned r;
    e = m_edit;
    if (grab(1)) e += 1;
    if (lp) e += 5;
    if (e > MAX_TIME) e = MIN_TIME;
    m_edit = e & 8'hFF;
    if (chg && grab(2)) begin
      if (w == 0) begin
        if (m_edit > m_yel) begin
          m_red = m_edit; m_grn = m_red - m_yel;
        end
      end else if (w == 1) begin
        if (m_red > m_edit) begin
          m_yel = m_edit; m_grn = m_red - m_yel;
        end
      end else begin
        r = m_edit + m_yel;
        m_grn = m_edit;
        m_red = r > 255 ? 255 : r;
      end
    end
    m_cd0 = m_edit;
    if (m_blink.flag) begin
      m_lamps = m_lamps ^ both_ways(1 << w);
      m_blink = arm(m_fast);
    end
    if (chg && m_dblink.flag) begin
      if (m_mask[0]) m_mask = m_mask & 4'hC;
      else m_mask = m_mask | 4'h3;
      m_dblink = arm(m_dig);
    end
  endfunction

  function automatic tlmc_out_t controller_pass(tlmc_in_t it);
    tlmc_out_t r;
    logic [3:0] s;
    int unsigned w;
    bit chg;
    s = m_state;
    if (it.tick) begin
      m_phase = count_down(m_phase); m_sec = count_down(m_sec);
      m_blink = count_down(m_blink); m_dblink = count_down(m_dblink);
    end
    if (it.mode_button_press) m_pend |= 1;
    if (it.adjust_button_press) m_pend |= 2;
    if (it.select_button_press) m_pend |= 4;
    case (s)
      ST_INIT: go_auto(ST_AUTO_RG);
      ST_AUTO_RG, ST_AUTO_RY, ST_AUTO_GR, ST_AUTO_YR: begin
        m_lamps = s == ST_AUTO_RG ? LAMPS_RG : s == ST_AUTO_RY ? LAMPS_RY :
                  s == ST_AUTO_GR ? LAMPS_GR : LAMPS_YR;
        if (m_sec.flag) begin
          m_cd0 = (m_cd0 - 1) & 8'hFF;
          m_cd1 = (m_cd1 - 1) & 8'hFF;
          m_sec = arm(m_tps);
        end
        if (m_phase.flag) go_auto(s == ST_AUTO_YR ? ST_AUTO_RG : s + 4'd1);
        else if (grab(0)) go_edit(0, 1'b0);
        else if (grab(1)) begin
          drop(2);
          m_lamps = LAMPS_YY;
          m_mask = 0;
          m_blink = arm(m_slow);
          m_state = ST_BLINK;
        end else if ((s == ST_AUTO_RG || s == ST_AUTO_GR) && grab(2)) go_manual(s + 4'd4);
      end
      ST_MAN_RG, ST_MAN_GR: begin
        m_mask = 0;
        m_lamps = s == ST_MAN_RG ? LAMPS_RG : LAMPS_GR;
        if (grab(1)) go_manual(s + 4'd1);
        else if (grab(2)) go_auto(s - 4'd4);
      end
      ST_MAN_RY, ST_MAN_YR: begin
        m_mask = 0;
        m_lamps = s == ST_MAN_RY ? LAMPS_RY : LAMPS_YR;
        if (m_phase.flag) go_manual(s == ST_MAN_RY ? ST_MAN_GR : ST_MAN_RG);
      end
      ST_BLINK: begin
        if (m_blink.flag) begin
          m_lamps = m_lamps ^ LAMPS_YY;
          m_blink = arm(m_slow);
        end
        if (grab(1)) go_auto(ST_AUTO_RG);
      end
      default: begin
        w = (s - ST_RED_EDIT) >> 1;
        chg = 1'((s - ST_RED_EDIT) & 1);
        run_edit(w, chg, it.adjust_button_long);
        if (grab(0)) begin
          if (w == 2) go_auto(ST_AUTO_RG);
          else go_edit(w + 1, 1'b0);
        end else if (!chg && m_edit != edited_time(w)) go_edit(w, 1'b1);
        else if (chg && m_edit == edited_time(w)) go_edit(w, 1'b0);
      end
    endcase
    r.way0_lamps = m_lamps[2:0];
    r.way1_lamps = m_lamps[5:3];
    r.left_display = m_cd0[7:0];
    r.right_display = m_cd1[7:0];
    r.digit_enables = m_mask[3:0];
    r.state_code = m_state;
    return r;
  endfunction

  // sender: bursts with gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    logic nv;
    tlmc_in_t nd;
    nv = in_valid;
    nd = in_data;
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_lights.push_back(controller_pass(in_data));
        items_sent++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) gap_left--;
        else if (pending_items.size() > 0) begin
          nd = pending_items.pop_front();
          nv = 1'b1;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
    in_valid <= nv;
    in_data <= nd;
  end

  // receiver: stall pattern with changing period and duty
  int stall_period = 1;
  int stall_duty = 0;
  int stall_pos = 0;
  always @(posedge clk) begin
    tlmc_out_t e;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      seen_states[out_data.state_code] = 1'b1;
      if (expected_lights.size() == 0) begin
        errors++;
        $display("%0t: unexpected item %h", $time, out_data);
      end else begin
        e = expected_lights.pop_front();
        if (e !== out_data) begin
          errors++;
          if (e.way0_lamps !== out_data.way0_lamps)
            $display("%0t: way0_lamps exp %h got %h", $time, e.way0_lamps, out_data.way0_lamps);
          if (e.way1_lamps !== out_data.way1_lamps)
            $display("%0t: way1_lamps exp %h got %h", $time, e.way1_lamps, out_data.way1_lamps);
          if (e.left_display !== out_data.left_display)
            $display("%0t: left_display exp %0d got %0d", $time, e.left_display,
                     out_data.left_display);
          if (e.right_display !== out_data.right_display)
            $display("%0t: right_display exp %0d got %0d", $time, e.right_display,
                     out_data.right_display);
          if (e.digit_enables !== out_data.digit_enables)
            $display("%0t: digit_enables exp %h got %h", $time, e.digit_enables,
                     out_data.digit_enables);
          if (e.state_code !== out_data.state_code)
            $display("%0t: state_code exp %0d got %0d", $time, e.state_code,
                     out_data.state_code);
        end
      end
    end
    if (stall_pos >= 63) begin
      stall_pos = 0;
      stall_period = $urandom_range(1, 8);
      stall_duty = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, stall_period);
    end else stall_pos++;
    out_ready <= (stall_pos % stall_period) >= stall_duty;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("traffic_light_mode_controller_top: mismatch");
      $finish;
    end
  end

  function automatic tlmc_in_t rand_item(int p_tick, int p_btn);
    tlmc_in_t it;
    it.tick = $urandom_range(0, 99) < p_tick;
    it.mode_button_press = $urandom_range(0, 99) < p_btn / 2;
    it.adjust_button_press = $urandom_range(0, 99) < p_btn;
    it.adjust_button_long = $urandom_range(0, 99) < p_btn / 2;
    it.select_button_press = $urandom_range(0, 99) < p_btn;
    return it;
  endfunction

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid || expected_lights.size() > 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_regs(int unsigned tps, int unsigned fst, int unsigned slw,
                            int unsigned dg);
    logic [15:0] v[4];
    v[0] = 16'(tps); v[1] = 16'(fst); v[2] = 16'(slw); v[3] = 16'(dg);
    for (int i = 0; i < 4; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= i[1:0];
      cfg_data <= v[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    m_tps = tps; m_fast = fst; m_slow = slw; m_dig = dg;
  endtask

  initial begin
    int unsigned tps_set[6] = '{1, 2, 65535, 3, 1, 4};
    int unsigned fast_set[6] = '{1, 3, 65535, 1, 65535, 2};
    int unsigned slow_set[6] = '{1, 5, 65535, 7, 2, 1};
    int unsigned dig_set[6] = '{1, 2, 65535, 4, 1, 65535};
    int n;
    tlmc_in_t it;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // directed: quiet, all ones, each input bit alone, edit chain walk
    pending_items.push_back('0);
    pending_items.push_back('1);
    for (int b = 0; b < 5; b++) begin
      it = '0;
      it[b] = 1'b1;
      pending_items.push_back(it);
      pending_items.push_back('0);
    end
    it = '0; it.mode_button_press = 1; pending_items.push_back(it);
    it = '0; it.adjust_button_long = 1; pending_items.push_back(it);
    it = '0; it.select_button_press = 1; pending_items.push_back(it);
    it = '0; it.mode_button_press = 1; pending_items.push_back(it);
    it = '0; it.adjust_button_press = 1; it.tick = 1; pending_items.push_back(it);
    it = '0; it.select_button_press = 1; pending_items.push_back(it);
    it = '0; it.mode_button_press = 1; pending_items.push_back(it);
    it = '0; it.adjust_button_long = 1; pending_items.push_back(it);
    it = '0; it.select_button_press = 1; pending_items.push_back(it);
    it = '0; it.mode_button_press = 1; pending_items.push_back(it);
    it = '0; it.adjust_button_press = 1; pending_items.push_back(it);
    pending_items.push_back('1);
    wait_idle();
    for (int p = 0; p < 6; p++) begin
      write_regs(tps_set[p], fast_set[p], slow_set[p], dig_set[p]);
      n = (tps_set[p] == 65535) ? 40 : 260;
      for (int i = 0; i < n; i++) begin
        if ((i / 40) % 3 == 2) pending_items.push_back(rand_item(50, 30));
        else if ((i / 40) % 3 == 1) pending_items.push_back(rand_item(95, 4));
        else pending_items.push_back(rand_item(80, 12));
      end
      wait_idle();
    end
    $display("%0d items sent, %0d results checked over 7 register settings; states seen %b",
             items_sent, results_seen, seen_states);
    if (errors == 0 && expected_lights.size() == 0) begin
      $display("traffic_light_mode_controller_top: match");
    end else begin
      $display("traffic_light_mode_controller_top: mismatch");
    end
    $finish;
  end

endmodule
